// ----- sv/utf8_to_ucs2_decoder_assert.svh -----
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define U8U2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define U8U2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/u8u2_pkg.sv -----
`default_nettype none

package u8u2_pkg;

  localparam logic [1:0] ST_CHAR     = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] partial_value;
    logic [1:0]  bytes_pending;
    logic        dropping;
  } dec_state_t;

endpackage

`default_nettype wire

// ----- sv/u8u2_dec.sv -----
`default_nettype none

module u8u2_dec
  import u8u2_pkg::*;
(
  input  wire dec_state_t cur,
  input  wire in_item_t   item,
  output dec_state_t      nxt,
  output logic            res_vld,
  output out_item_t       res
);

  logic [7:0]  b;
  logic        eos;
  logic [15:0] shifted;
  logic [1:0]  pend_dec;

  assign b        = item.in_byte;
  assign eos      = item.end_of_string;
  assign shifted  = {cur.partial_value[9:0], b[5:0]};
  assign pend_dec = cur.bytes_pending - 2'd1;

  always_comb begin
    nxt     = cur;
    res_vld = 1'b0;
    res     = '0;
    if (cur.dropping) begin
      if (eos) begin
        nxt = '0;
      end
    end else if (cur.bytes_pending != PEND_NONE) begin
      if (pend_dec == PEND_NONE) begin
        nxt.partial_value = '0;
        nxt.bytes_pending = PEND_NONE;
        res_vld           = 1'b1;
        res.code_unit     = shifted;
        res.status        = ST_CHAR;
        res.last          = eos;
      end else if (eos) begin
        nxt        = '0;
        res_vld    = 1'b1;
        res.status = ST_TRUNC;
        res.last   = 1'b1;
      end else begin
        nxt.partial_value = shifted;
        nxt.bytes_pending = pend_dec;
      end
    end else begin
      case (b) inside
        8'b0???????: begin
          res_vld       = 1'b1;
          res.code_unit = {8'h00, b};
          res.status    = ST_CHAR;
          res.last      = eos;
        end
        8'b110?????: begin
          if (eos) begin
            nxt        = '0;
            res_vld    = 1'b1;
            res.status = ST_TRUNC;
            res.last   = 1'b1;
          end else begin
            nxt.partial_value = {11'd0, b[4:0]};
            nxt.bytes_pending = PEND_ONE;
          end
        end
        8'b1110????: begin
          if (eos) begin
            nxt        = '0;
            res_vld    = 1'b1;
            res.status = ST_TRUNC;
            res.last   = 1'b1;
          end else begin
            nxt.partial_value = {12'd0, b[3:0]};
            nxt.bytes_pending = PEND_TWO;
          end
        end
        default: begin
          nxt          = '0;
          nxt.dropping = !eos;
          res_vld      = 1'b1;
          res.status   = ST_BAD_LEAD;
          res.last     = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/utf8_to_ucs2_decoder.sv -----
// Streaming UTF-8 to UCS-2 decoder. Bytes enter on the in_ channel, one per
// transfer, with end_of_string set on the final byte of each string; each
// completed one-, two- or three-byte sequence leaves as one 16-bit code unit
// on the out_ channel, and invalid lead bytes and strings that end inside a
// sequence give an error result with last set. The block takes one byte per
// clock when the output is not stalled. A byte is held in an input register,
// decoded in a single pass against the sequence state, and any result it
// completes is registered in the output register that drives out_valid and
// out_data. An output stall holds the input register and stalls the input
// while that register holds a byte.
`default_nettype none
`include "utf8_to_ucs2_decoder_assert.svh"

module utf8_to_ucs2_decoder
  import u8u2_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_item_r;
  dec_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  logic       advance;
  logic       fire;
  dec_state_t dec_nxt;
  logic       res_vld;
  out_item_t  res;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign fire     = s1_valid_r && advance;

  u8u2_dec u_dec (
    .cur     (state_r),
    .item    (s1_item_r),
    .nxt     (dec_nxt),
    .res_vld (res_vld),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    state_nxt     = fire ? dec_nxt : state_r;
    out_valid_nxt = advance ? (s1_valid_r && res_vld) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_data;
    end
    if (fire && res_vld) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `U8U2_ASSERT_NOW(a_pend_range, 1'b1, state_r.bytes_pending != 2'd3,
    "bytes_pending reached an impossible count")
  `U8U2_ASSERT_NOW(a_drop_excl, state_r.dropping, state_r.bytes_pending == PEND_NONE,
    "dropping while a sequence is pending")
  `U8U2_ASSERT_NOW(a_err_last, out_valid_r && (out_item_r.status != ST_CHAR),
    out_item_r.last && (out_item_r.code_unit == 16'd0),
    "error result without last or with a nonzero code unit")
  `U8U2_ASSERT_NEXT(a_eos_clear, fire && s1_item_r.end_of_string,
    state_r.bytes_pending == PEND_NONE && !state_r.dropping,
    "state not cleared after end of string")

endmodule

`default_nettype wire
